### rtl/sbpp_pkg.sv
// Shared types and constants for the six-button pad poller.
package sbpp_pkg;

  localparam int PIN_W     = 6;
  localparam int BTN_W     = 12;
  localparam int IDLE_W    = 16;
  localparam int PULSE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [IDLE_W-1:0]  IDLE_TICKS_RST  = IDLE_W'(1000);
  localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = PULSE_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [IDLE_W-1:0]  idle_ticks;
    logic [PULSE_W-1:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic             select_level;
    logic [BTN_W-1:0] buttons;
    logic             changed;
  } res_t;

endpackage

### rtl/six_button_pad_poller_core.sv
// Six-button pad poller: config registers, sequencer and result buffer.
// A result beat is registered in the output register, or in the skid slot while the output register is held.
// Throughput: one beat per cycle while in_stall is low; each beat steps the sequencer's phase or its counters.
// in_stall rises only when the output register and its skid slot are both full.
// Synchronous active-low reset: sequencer at snapshot, select high, buttons clear,
// idle_ticks 1000, pulse_ticks 2, result buffer empty.
module six_button_pad_poller_core
  import sbpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIN_W-1:0]     in_pin_levels,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_select_level,
  output logic [BTN_W-1:0]     out_buttons,
  output logic                 out_changed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg_r;
  res_t res;
  res_t out_data;
  logic full;
  logic step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_ticks  <= IDLE_TICKS_RST;
      cfg_r.pulse_ticks <= PULSE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDLE_TICKS:  cfg_r.idle_ticks  <= cfg_data[IDLE_W-1:0];
        CFG_PULSE_TICKS: cfg_r.pulse_ticks <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign step     = in_valid && !full;

  sbpp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .pin_levels (in_pin_levels),
    .cfg        (cfg_r),
    .res        (res)
  );

  sbpp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_select_level = out_data.select_level;
  assign out_buttons      = out_data.buttons;
  assign out_changed      = out_data.changed;

endmodule

### rtl/sbpp_seq.sv
// Polling sequencer: phase, counters and button state, updated on each beat.
module sbpp_seq
  import sbpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [PIN_W-1:0] pin_levels,
  input  cfg_t             cfg,
  output res_t             res
);

  localparam logic [3:0] PH_SNAP     = 4'd0;
  localparam logic [3:0] PH_SEL_HI   = 4'd1;
  localparam logic [3:0] PH_READ_HI  = 4'd2;
  localparam logic [3:0] PH_SEL_LO   = 4'd3;
  localparam logic [3:0] PH_READ_LO  = 4'd4;
  localparam logic [3:0] PH_P1_LO    = 4'd5;
  localparam logic [3:0] PH_P1_HI    = 4'd6;
  localparam logic [3:0] PH_P2_LO    = 4'd7;
  localparam logic [3:0] PH_P2_HI    = 4'd8;
  localparam logic [3:0] PH_P3_LO    = 4'd9;
  localparam logic [3:0] PH_P3_HI    = 4'd10;
  localparam logic [3:0] PH_READ_XYZ = 4'd11;
  localparam logic [3:0] PH_COMPARE  = 4'd12;
  localparam logic [3:0] PH_IDLE     = 4'd13;

  logic [3:0]         phase_r, phase_nxt;
  logic [IDLE_W-1:0]  idle_cnt_r, idle_cnt_nxt;
  logic [PULSE_W-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [BTN_W-1:0]   cur_r, cur_nxt;
  logic [BTN_W-1:0]   prev_r, prev_nxt;
  logic               sel_r, sel_nxt;
  logic               changed;
  logic [PIN_W-1:0]   pressed;

  assign pressed = ~pin_levels;

  always_comb begin
    phase_nxt     = phase_r;
    idle_cnt_nxt  = idle_cnt_r;
    pulse_cnt_nxt = pulse_cnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    sel_nxt       = sel_r;
    changed       = 1'b0;
    unique case (phase_r) inside
      PH_SNAP: begin
        prev_nxt     = cur_r;
        idle_cnt_nxt = cfg.idle_ticks;
        phase_nxt    = PH_SEL_HI;
      end
      PH_SEL_HI: begin
        sel_nxt   = 1'b1;
        phase_nxt = PH_READ_HI;
      end
      PH_READ_HI: begin
        cur_nxt[3:0] = pressed[3:0];
        cur_nxt[5]   = pressed[4];
        cur_nxt[6]   = pressed[5];
        phase_nxt    = PH_SEL_LO;
      end
      PH_SEL_LO: begin
        sel_nxt   = 1'b0;
        phase_nxt = PH_READ_LO;
      end
      PH_READ_LO: begin
        cur_nxt[4] = pressed[4];
        cur_nxt[7] = pressed[5];
        phase_nxt  = PH_P1_LO;
      end
      PH_P1_LO, PH_P1_HI, PH_P2_LO, PH_P2_HI, PH_P3_LO, PH_P3_HI: begin
        if (pulse_cnt_r != '0) begin
          pulse_cnt_nxt = pulse_cnt_r - PULSE_W'(1);
          sel_nxt       = ~phase_r[0];
        end else begin
          pulse_cnt_nxt = cfg.pulse_ticks;
          phase_nxt     = phase_r + 4'd1;
        end
      end
      PH_READ_XYZ: begin
        cur_nxt[10]   = pressed[0];
        cur_nxt[9]    = pressed[1];
        cur_nxt[8]    = pressed[2];
        cur_nxt[11]   = pressed[3];
        pulse_cnt_nxt = cfg.pulse_ticks;
        phase_nxt     = PH_COMPARE;
      end
      PH_COMPARE: begin
        changed   = (cur_r != prev_r);
        phase_nxt = PH_IDLE;
      end
      PH_IDLE: begin
        if (idle_cnt_r != '0) begin
          idle_cnt_nxt = idle_cnt_r - IDLE_W'(1);
        end else begin
          phase_nxt = PH_SNAP;
        end
      end
      default: begin
        phase_nxt = PH_SNAP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SNAP;
      idle_cnt_r  <= '0;
      pulse_cnt_r <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      sel_r       <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign res.select_level = sel_nxt;
  assign res.buttons      = cur_nxt;
  assign res.changed      = changed;

endmodule

### rtl/sbpp_skid.sv
// Output register with skid slot for result beats.
module sbpp_skid
  import sbpp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  assign take = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (take) begin
      out_vld_nxt = 1'b0;
    end
    if (take && skid_vld_r) begin
      out_nxt      = skid_r;
      out_vld_nxt  = 1'b1;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!out_vld_nxt) begin
        out_nxt     = push_data;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### bench/six_button_pad_poller_core_test.sv
// Testbench for the six-button pad poller core: table-driven and random ticks checked by table or predictor.
`timescale 1ns / 1ps

module six_button_pad_poller_core_test;
  import sbpp_pkg::*;

  localparam int LIMIT    = 100000;
  localparam int DIR_ROWS = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    SNAPSHOT, DRIVE_HI, READ_HI, DRIVE_LO, READ_LO,
    P1_LO, P1_HI, P2_LO, P2_HI, P3_LO, P3_HI,
    READ_XYZM, COMPARE, IDLE_WAIT
  } seq_t;

  typedef struct {
    logic [PIN_W-1:0] pins;
    bit               typed;
    res_t             want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [PIN_W-1:0]     in_pin_levels    = '1;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic                 out_select_level;
  logic [BTN_W-1:0]     out_buttons;
  logic                 out_changed;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DAT_W-1:0] cfg_data         = '0;

  seq_t               seq        = SNAPSHOT;
  logic [IDLE_W:0]    idle_left  = '0;
  logic [PULSE_W:0]   pulse_left = '0;
  logic [BTN_W-1:0]   btn_now    = '0;
  logic [BTN_W-1:0]   btn_snap   = '0;
  logic               sel_now    = 1'b1;
  logic [IDLE_W-1:0]  cfg_idle   = IDLE_TICKS_RST;
  logic [PULSE_W-1:0] cfg_pulse  = PULSE_TICKS_RST;

  res_t             pad_results_q[$];
  res_t             want_now;
  dir_row_t         dir_tab[DIR_ROWS];
  logic [PIN_W-1:0] held_pins = '1;
  int               mismatches = 0;
  int               cycles = 0;
  int               src_gap_pct = 0;
  int               sink_stall_pct = 0;

  six_button_pad_poller_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_select_level (out_select_level),
    .out_buttons      (out_buttons),
    .out_changed      (out_changed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic void pulse_half(logic lv, seq_t nxt);
    if (pulse_left != 0) begin
      pulse_left = pulse_left - 1'b1;
      sel_now    = lv;
    end else begin
      pulse_left = {1'b0, cfg_pulse};
      seq        = nxt;
    end
  endfunction

  function automatic res_t poll_tick(logic [PIN_W-1:0] pins);
    logic [PIN_W-1:0] pressed;
    res_t             r;
    pressed   = ~pins;
    r.changed = 1'b0;
    case (seq)
      SNAPSHOT: begin
        btn_snap  = btn_now;
        idle_left = {1'b0, cfg_idle};
        seq       = DRIVE_HI;
      end
      DRIVE_HI: begin
        sel_now = 1'b1;
        seq     = READ_HI;
      end
      READ_HI: begin
        btn_now[3:0] = pressed[3:0];
        btn_now[5]   = pressed[4];
        btn_now[6]   = pressed[5];
        seq          = DRIVE_LO;
      end
      DRIVE_LO: begin
        sel_now = 1'b0;
        seq     = READ_LO;
      end
      READ_LO: begin
        btn_now[4] = pressed[4];
        btn_now[7] = pressed[5];
        seq        = P1_LO;
      end
      P1_LO: pulse_half(1'b0, P1_HI);
      P1_HI: pulse_half(1'b1, P2_LO);
      P2_LO: pulse_half(1'b0, P2_HI);
      P2_HI: pulse_half(1'b1, P3_LO);
      P3_LO: pulse_half(1'b0, P3_HI);
      P3_HI: pulse_half(1'b1, READ_XYZM);
      READ_XYZM: begin
        btn_now[10] = pressed[0];
        btn_now[9]  = pressed[1];
        btn_now[8]  = pressed[2];
        btn_now[11] = pressed[3];
        pulse_left  = {1'b0, cfg_pulse};
        seq         = COMPARE;
      end
      COMPARE: begin
        r.changed = (btn_now != btn_snap);
        seq       = IDLE_WAIT;
      end
      IDLE_WAIT: begin
        if (idle_left != 0) begin
          idle_left = idle_left - 1'b1;
        end else begin
          seq = SNAPSHOT;
        end
      end
      default: seq = SNAPSHOT;
    endcase
    r.select_level = sel_now;
    r.buttons      = btn_now;
    return r;
  endfunction

  function automatic logic [PIN_W-1:0] next_pins();
    if ($urandom_range(39) == 0) begin
      held_pins = PIN_W'($urandom);
    end
    return ($urandom_range(3) == 0) ? PIN_W'($urandom) : held_pins;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDLE_TICKS) begin
      cfg_idle = data[IDLE_W-1:0];
    end else if (idx == CFG_PULSE_TICKS) begin
      cfg_pulse = data[PULSE_W-1:0];
    end
  endtask

  task automatic drive_beat(logic [PIN_W-1:0] pins, bit typed, res_t want);
    res_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = poll_tick(pins);
    pad_results_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pad_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_random(int n, bit pause_ok);
    for (int i = 0; i < n; i++) begin
      if (pause_ok && (i == 100 || $urandom_range(49) == 0)) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pad_results_q.size() != 0) @(posedge clk);
      end
      drive_beat(next_pins(), 1'b0, '0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pad_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat sel=%0d buttons=%03h changed=%0d",
                 $time, out_select_level, out_buttons, out_changed);
      end else begin
        want_now = pad_results_q.pop_front();
        if (out_select_level !== want_now.select_level) begin
          mismatches++;
          $display("%0t: select_level expected %0d got %0d",
                   $time, want_now.select_level, out_select_level);
        end
        if (out_buttons !== want_now.buttons) begin
          mismatches++;
          $display("%0t: buttons expected %03h got %03h",
                   $time, want_now.buttons, out_buttons);
        end
        if (out_changed !== want_now.changed) begin
          mismatches++;
          $display("%0t: changed expected %0d got %0d",
                   $time, want_now.changed, out_changed);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DIR_ROWS; i++) begin
      dir_tab[i].pins  = (i % 2) ? 6'h15 : 6'h2A;
      dir_tab[i].typed = 1'b0;
      dir_tab[i].want  = '0;
    end
    // first round after reset: one-tick first pulse half, then pulse_ticks of 2
    dir_tab[0]  = '{6'h3F, 1'b1, '{1'b1, 12'h000, 1'b0}};
    dir_tab[1]  = '{6'h00, 1'b1, '{1'b1, 12'h000, 1'b0}};
    dir_tab[2]  = '{6'h00, 1'b1, '{1'b1, 12'h06F, 1'b0}};
    dir_tab[3]  = '{6'h3F, 1'b1, '{1'b0, 12'h06F, 1'b0}};
    dir_tab[4]  = '{6'h00, 1'b1, '{1'b0, 12'h0FF, 1'b0}};
    dir_tab[21] = '{6'h00, 1'b1, '{1'b1, 12'hFFF, 1'b0}};
    dir_tab[22] = '{6'h3F, 1'b1, '{1'b1, 12'hFFF, 1'b1}};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct    = 24;
    sink_stall_pct = 58;
    write_reg(CFG_IDLE_TICKS, 16'd3);
    write_reg(CFG_UNUSED_B, 16'hFFFF);
    for (int i = 0; i < DIR_ROWS; i++) begin
      drive_beat(dir_tab[i].pins, dir_tab[i].typed, dir_tab[i].want);
    end
    // all released for a round, then all pressed
    for (int i = 0; i < 30; i++) drive_beat(6'h3F, 1'b0, '0);
    for (int i = 0; i < 30; i++) drive_beat(6'h00, 1'b0, '0);
    run_random(250, 1'b0);

    write_reg(CFG_IDLE_TICKS, 16'd0);
    write_reg(CFG_PULSE_TICKS, 16'hFF00);
    run_random(250, 1'b0);

    src_gap_pct    = 58;
    sink_stall_pct = 24;
    write_reg(CFG_IDLE_TICKS, 16'd7);
    write_reg(CFG_PULSE_TICKS, 16'd1);
    run_random(250, 1'b1);

    write_reg(CFG_IDLE_TICKS, 16'h0013);
    write_reg(CFG_PULSE_TICKS, 16'd3);
    write_reg(CFG_UNUSED_A, 16'h5A5A);
    run_random(250, 1'b1);

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    write_reg(CFG_IDLE_TICKS, 16'd1);
    write_reg(CFG_PULSE_TICKS, 16'd255);
    run_random(150, 1'b0);

    // enter the longest idle wait
    write_reg(CFG_PULSE_TICKS, 16'hA505);
    write_reg(CFG_IDLE_TICKS, 16'hFFFF);
    run_random(120, 1'b0);

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
